// ===== sv/taq_pkg.sv =====
// Shared types and constants for the tick alarm queue.
// Holds the queue geometry, the entry layout and the control/status structs.
// Depends on nothing.
package taq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_OUT     = 16;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = PTR_W + 1;
    localparam int NFIRE_W = $clog2(MAX_OUT + 1);

    localparam int DELAY_W  = 16;
    localparam int TAG_W    = 8;
    localparam int TICK_W   = 64;
    localparam int STATUS_W = 2;

    // Division by 100 is a multiply by 2^24 / 100 rounded up, then a shift.
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] MS_RECIP = 18'd167773;
    localparam int PROD_W      = DELAY_W + RECIP_W;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_FIRED    = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NEXT,
        RD_LAST,
        RD_PREV
    } t_rd_sel;

    typedef struct packed {
        logic [TICK_W-1:0] due;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef struct packed {
        logic    load_item;
        logic    tick_inc;
        logic    calc_due;
        t_rd_sel rd_sel;
        logic    idx_load_last;
        logic    idx_dec;
        logic    wr_en;
        logic    wr_shift;
        logic    wr_at_head;
        logic    cnt_inc;
        logic    pop;
        logic    fire_push;
        logic    fire_flush;
        logic    emit_set;
        t_status emit_status;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_set;
        logic in_zero;
        logic full;
        logic empty;
        logic idx_zero;
        logic move_up;
        logic fire_ok;
    } t_dp_stat;

endpackage

// ===== sv/taq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the alarm entry store. Depends on nothing.
module taq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== sv/taq_dp.sv =====
// Datapath of the tick alarm queue: tick counter, due-time arithmetic,
// ring-buffer pointers over the entry RAM and the result registers.
// Depends on taq_pkg and taq_ram.
module taq_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_opcode,
    input  logic [taq_pkg::DELAY_W-1:0]        i_delay_ms,
    input  logic [taq_pkg::TAG_W-1:0]          i_alarm_tag,
    input  taq_pkg::t_ctl_cmd                  i_cmd,
    output taq_pkg::t_dp_stat                  o_stat,
    output logic                               o_strobe,
    output logic [taq_pkg::STATUS_W-1:0]       o_status,
    output logic [taq_pkg::TAG_W-1:0]          o_fired_tag,
    output logic [taq_pkg::TICK_W-1:0]         o_now_ticks,
    output logic                               o_last
);

    localparam logic [taq_pkg::SUM_W-1:0] DEPTH_SUM = taq_pkg::SUM_W'(taq_pkg::QUEUE_DEPTH);

    function automatic logic [taq_pkg::PTR_W-1:0] ring_addr(
        input logic [taq_pkg::PTR_W-1:0] base,
        input logic [taq_pkg::PTR_W-1:0] off
    );
        logic [taq_pkg::SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_SUM) begin
            sum = sum - DEPTH_SUM;
        end
        return sum[taq_pkg::PTR_W-1:0];
    endfunction

    logic [taq_pkg::TICK_W-1:0]  r_tick, n_tick;
    logic [taq_pkg::CNT_W-1:0]   r_count, n_count;
    logic [taq_pkg::PTR_W-1:0]   r_head, n_head;
    logic [taq_pkg::PTR_W-1:0]   r_idx, n_idx;
    logic [taq_pkg::NFIRE_W-1:0] r_nfire, n_nfire;
    logic                        r_pend_v, n_pend_v;
    logic [taq_pkg::TAG_W-1:0]   r_pend_tag, n_pend_tag;
    logic [taq_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [taq_pkg::TICK_W-1:0]  r_due, n_due;
    logic [taq_pkg::TAG_W-1:0]   r_tag, n_tag;

    logic                        r_out_v, n_out_v;
    taq_pkg::t_status            r_out_status, n_out_status;
    logic [taq_pkg::TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [taq_pkg::TICK_W-1:0]  r_out_now, n_out_now;
    logic                        r_last, n_last;

    logic [taq_pkg::PTR_W-1:0]   rd_off;
    logic [taq_pkg::PTR_W-1:0]   wr_off;
    logic [$bits(taq_pkg::t_entry)-1:0] ram_rd_data;
    taq_pkg::t_entry             rd_entry;
    taq_pkg::t_entry             wr_entry;

    always_comb begin
        unique case (i_cmd.rd_sel)
            taq_pkg::RD_HEAD: rd_off = '0;
            taq_pkg::RD_NEXT: rd_off = taq_pkg::PTR_W'(1);
            taq_pkg::RD_LAST: rd_off = taq_pkg::PTR_W'(r_count - taq_pkg::CNT_W'(1));
            taq_pkg::RD_PREV: rd_off = r_idx - taq_pkg::PTR_W'(1);
            default:          rd_off = '0;
        endcase
    end

    assign wr_off   = i_cmd.wr_at_head ? '0 : r_idx + taq_pkg::PTR_W'(1);
    assign rd_entry = taq_pkg::t_entry'(ram_rd_data);
    assign wr_entry = i_cmd.wr_shift ? rd_entry : taq_pkg::t_entry'({r_due, r_tag});

    taq_ram #(
        .WIDTH($bits(taq_pkg::t_entry)),
        .DEPTH(taq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (ring_addr(r_head, wr_off)),
        .i_wr_data (wr_entry),
        .i_rd_addr (ring_addr(r_head, rd_off)),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        o_stat.in_set   = (i_opcode == taq_pkg::OP_SET);
        o_stat.in_zero  = (i_delay_ms == '0);
        o_stat.full     = (r_count == taq_pkg::CNT_W'(taq_pkg::QUEUE_DEPTH));
        o_stat.empty    = (r_count == '0);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.move_up  = (rd_entry.due > r_due);
        o_stat.fire_ok  = (r_count != '0) && (rd_entry.due <= r_tick)
                          && (r_nfire != taq_pkg::NFIRE_W'(taq_pkg::MAX_OUT));
    end

    always_comb begin
        n_tick       = r_tick;
        n_count      = r_count;
        n_head       = r_head;
        n_idx        = r_idx;
        n_nfire      = r_nfire;
        n_pend_v     = r_pend_v;
        n_pend_tag   = r_pend_tag;
        n_prod       = r_prod;
        n_due        = r_due;
        n_tag        = r_tag;
        n_out_v      = 1'b0;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        n_out_now    = r_out_now;
        n_last       = r_last;

        if (i_cmd.load_item) begin
            n_tag   = i_alarm_tag;
            n_prod  = taq_pkg::PROD_W'(i_delay_ms) * taq_pkg::PROD_W'(taq_pkg::MS_RECIP);
            n_nfire = '0;
        end
        if (i_cmd.tick_inc) begin
            n_tick = r_tick + taq_pkg::TICK_W'(1);
        end
        if (i_cmd.calc_due) begin
            n_due = r_tick
                    + taq_pkg::TICK_W'(r_prod[taq_pkg::PROD_W-1:taq_pkg::RECIP_SHIFT]);
        end
        if (i_cmd.idx_load_last) begin
            n_idx = taq_pkg::PTR_W'(r_count - taq_pkg::CNT_W'(1));
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - taq_pkg::PTR_W'(1);
        end
        if (i_cmd.cnt_inc) begin
            n_count = r_count + taq_pkg::CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - taq_pkg::CNT_W'(1);
            n_head  = ring_addr(r_head, taq_pkg::PTR_W'(1));
        end

        if (i_cmd.emit_set) begin
            n_out_v      = 1'b1;
            n_out_status = i_cmd.emit_status;
            n_out_tag    = r_tag;
            n_out_now    = r_tick;
            n_last       = 1'b1;
        end
        if (i_cmd.fire_push) begin
            n_nfire    = r_nfire + taq_pkg::NFIRE_W'(1);
            n_pend_v   = 1'b1;
            n_pend_tag = rd_entry.tag;
            if (r_pend_v) begin
                n_out_v      = 1'b1;
                n_out_status = taq_pkg::ST_FIRED;
                n_out_tag    = r_pend_tag;
                n_out_now    = r_tick;
                n_last       = 1'b0;
            end
        end
        if (i_cmd.fire_flush) begin
            n_pend_v = 1'b0;
            if (r_pend_v) begin
                n_out_v      = 1'b1;
                n_out_status = taq_pkg::ST_FIRED;
                n_out_tag    = r_pend_tag;
                n_out_now    = r_tick;
                n_last       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_count  <= '0;
            r_head   <= '0;
            r_idx    <= '0;
            r_nfire  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_tick   <= n_tick;
            r_count  <= n_count;
            r_head   <= n_head;
            r_idx    <= n_idx;
            r_nfire  <= n_nfire;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_tag   <= n_pend_tag;
        r_prod       <= n_prod;
        r_due        <= n_due;
        r_tag        <= n_tag;
        r_out_status <= n_out_status;
        r_out_tag    <= n_out_tag;
        r_out_now    <= n_out_now;
        r_last       <= n_last;
    end

    assign o_strobe    = r_out_v;
    assign o_status    = r_out_status;
    assign o_fired_tag = r_out_tag;
    assign o_now_ticks = r_out_now;
    assign o_last      = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= taq_pkg::CNT_W'(taq_pkg::QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("An entry was removed from an empty queue.");

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= taq_pkg::NFIRE_W'(taq_pkg::MAX_OUT))
        else $error("More alarms fired on one tick than allowed.");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire_flush && r_pend_v)
        |=> (r_out_v && r_last && (r_out_status == taq_pkg::ST_FIRED)))
        else $error("The final fired alarm was not reported with its last marker.");

endmodule

// ===== sv/taq_ctrl.sv =====
// Controller state machine of the tick alarm queue.
// Sequences sorted insertion and the drain of due alarms. Depends on taq_pkg.
module taq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  taq_pkg::t_dp_stat i_stat,
    output taq_pkg::t_ctl_cmd o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IGN,
        S_REJ,
        S_DUE,
        S_INS,
        S_PUT,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state             = r_state;
        o_cmd               = '0;
        o_cmd.rd_sel        = taq_pkg::RD_HEAD;
        o_cmd.emit_status   = taq_pkg::ST_ACCEPTED;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    if (i_stat.in_set) begin
                        if (i_stat.in_zero) begin
                            n_state = S_IGN;
                        end else if (i_stat.full) begin
                            n_state = S_REJ;
                        end else begin
                            n_state = S_DUE;
                        end
                    end else begin
                        o_cmd.tick_inc = 1'b1;
                        n_state        = S_DRAIN;
                    end
                end
            end
            S_IGN: begin
                o_cmd.emit_set    = 1'b1;
                o_cmd.emit_status = taq_pkg::ST_ZERO;
                n_state           = S_IDLE;
            end
            S_REJ: begin
                o_cmd.emit_set    = 1'b1;
                o_cmd.emit_status = taq_pkg::ST_FULL;
                n_state           = S_IDLE;
            end
            S_DUE: begin
                o_cmd.calc_due = 1'b1;
                if (i_stat.empty) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.rd_sel        = taq_pkg::RD_LAST;
                    o_cmd.idx_load_last = 1'b1;
                    n_state             = S_INS;
                end
            end
            S_INS: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.move_up) begin
                    o_cmd.wr_shift = 1'b1;
                    if (i_stat.idx_zero) begin
                        n_state = S_PUT;
                    end else begin
                        o_cmd.rd_sel  = taq_pkg::RD_PREV;
                        o_cmd.idx_dec = 1'b1;
                    end
                end else begin
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.emit_set = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_PUT: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_at_head = 1'b1;
                o_cmd.cnt_inc    = 1'b1;
                o_cmd.emit_set   = 1'b1;
                n_state          = S_IDLE;
            end
            S_DRAIN: begin
                if (i_stat.fire_ok) begin
                    o_cmd.fire_push = 1'b1;
                    o_cmd.pop       = 1'b1;
                    o_cmd.rd_sel    = taq_pkg::RD_NEXT;
                end else begin
                    o_cmd.fire_flush = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== sv/tick_alarm_queue.sv =====
// Set alarm: a zero delay or a full queue is answered from the S_IGN or S_REJ state; an insertion
// passes S_DUE, then stays in S_INS while it moves later-due entries up, or goes to S_PUT, then reports.
// Tick: fired results come from S_DRAIN, one per cycle; busy stays high while due alarms are
// fired and the last one is flushed. Time is set by the serial walk over the entry RAM port.
// Synchronous reset clears the tick count and empties the queue at once; RAM is not swept.
// The receiver cannot stall: each result is shown for exactly one cycle. Depends on taq_pkg.
module tick_alarm_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [taq_pkg::DELAY_W-1:0]  i_delay_ms,
    input  logic [taq_pkg::TAG_W-1:0]    i_alarm_tag,
    output logic                         o_strobe,
    output logic [taq_pkg::STATUS_W-1:0] o_status,
    output logic [taq_pkg::TAG_W-1:0]    o_fired_tag,
    output logic [taq_pkg::TICK_W-1:0]   o_now_ticks,
    output logic                         o_last
);

    taq_pkg::t_ctl_cmd cmd;
    taq_pkg::t_dp_stat stat;

    taq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    taq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_opcode    (i_opcode),
        .i_delay_ms  (i_delay_ms),
        .i_alarm_tag (i_alarm_tag),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_fired_tag (o_fired_tag),
        .o_now_ticks (o_now_ticks),
        .o_last      (o_last)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for tick_alarm_queue: directed and random transactions with a
// predictor of the tick count and the time-ordered alarm queue that checks every result.
// Depends on taq_pkg and the tick_alarm_queue RTL.
module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_CYCLES     = 40;
    localparam int DRAIN_TICKS    = 12;

    typedef struct {
        logic [taq_pkg::TICK_W-1:0] due;
        logic [taq_pkg::TAG_W-1:0]  tag;
    } t_alarm;

    typedef struct {
        taq_pkg::t_status           status;
        logic [taq_pkg::TAG_W-1:0]  tag;
        logic [taq_pkg::TICK_W-1:0] now;
        logic                       last;
    } t_report;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         start       = 1'b0;
    logic                         i_opcode    = taq_pkg::OP_TICK;
    logic [taq_pkg::DELAY_W-1:0]  i_delay_ms  = '0;
    logic [taq_pkg::TAG_W-1:0]    i_alarm_tag = '0;
    logic                         busy;
    logic                         o_strobe;
    logic [taq_pkg::STATUS_W-1:0] o_status;
    logic [taq_pkg::TAG_W-1:0]    o_fired_tag;
    logic [taq_pkg::TICK_W-1:0]   o_now_ticks;
    logic                         o_last;

    t_alarm                     model_alarms[$];
    t_report                    expected_reports[$];
    logic [taq_pkg::TICK_W-1:0] model_ticks  = '0;
    int                         fail_count   = 0;
    int                         idle_pct     = 0;
    int                         stall_cycles = 0;

    tick_alarm_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_delay_ms  (i_delay_ms),
        .i_alarm_tag (i_alarm_tag),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_fired_tag (o_fired_tag),
        .o_now_ticks (o_now_ticks),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void add_report(taq_pkg::t_status status,
                                       logic [taq_pkg::TAG_W-1:0] tag, logic last);
        t_report r;
        r.status = status;
        r.tag    = tag;
        r.now    = model_ticks;
        r.last   = last;
        expected_reports.push_back(r);
    endfunction

    function automatic void predict_alarm_queue(taq_pkg::t_opcode op,
                                                logic [taq_pkg::DELAY_W-1:0] delay,
                                                logic [taq_pkg::TAG_W-1:0] tag);
        int     pos;
        int     fired;
        t_alarm entry;
        if (op == taq_pkg::OP_SET) begin
            if (delay == '0) begin
                add_report(taq_pkg::ST_ZERO, tag, 1'b1);
            end else if (model_alarms.size() >= taq_pkg::QUEUE_DEPTH) begin
                add_report(taq_pkg::ST_FULL, tag, 1'b1);
            end else begin
                entry.due = model_ticks + taq_pkg::TICK_W'(delay / 16'd100);
                entry.tag = tag;
                pos = 0;
                while (pos < model_alarms.size() && model_alarms[pos].due <= entry.due)
                    pos++;
                model_alarms.insert(pos, entry);
                add_report(taq_pkg::ST_ACCEPTED, tag, 1'b1);
            end
        end else begin
            model_ticks = model_ticks + 1'b1;
            fired = 0;
            while (fired < taq_pkg::MAX_OUT && model_alarms.size() > 0
                   && model_alarms[0].due <= model_ticks) begin
                add_report(taq_pkg::ST_FIRED, model_alarms[0].tag, 1'b0);
                void'(model_alarms.pop_front());
                fired++;
            end
            if (fired > 0)
                expected_reports[expected_reports.size()-1].last = 1'b1;
        end
    endfunction

    // Holds the transaction until it is taken, then records what it should produce.
    task automatic issue_command(taq_pkg::t_opcode op, logic [taq_pkg::DELAY_W-1:0] delay,
                                 logic [taq_pkg::TAG_W-1:0] tag);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_opcode    <= op;
        i_delay_ms  <= delay;
        i_alarm_tag <= tag;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_alarm_queue(op, delay, tag);
    endtask

    function automatic logic [taq_pkg::DELAY_W-1:0] pick_delay();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return '0;
        if (sel < 15)
            return taq_pkg::DELAY_W'($urandom_range(1, 99));
        if (sel < 97)
            return taq_pkg::DELAY_W'($urandom_range(100, 1599));
        return taq_pkg::DELAY_W'($urandom_range(0, 65535));
    endfunction

    task automatic test_zero_and_short_delays();
        issue_command(taq_pkg::OP_SET, 16'd0, 8'h00);
        issue_command(taq_pkg::OP_SET, 16'd99, 8'hA5);
        issue_command(taq_pkg::OP_SET, 16'd100, 8'h5A);
        issue_command(taq_pkg::OP_SET, 16'd199, 8'h3C);
        issue_command(taq_pkg::OP_TICK, 16'd0, 8'h00);
        issue_command(taq_pkg::OP_TICK, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_full_queue_and_max_burst();
        for (int i = 0; i < taq_pkg::QUEUE_DEPTH; i++)
            issue_command(taq_pkg::OP_SET, 16'd250, taq_pkg::TAG_W'(8'hF0 + i));
        issue_command(taq_pkg::OP_SET, 16'd300, 8'h77);
        issue_command(taq_pkg::OP_SET, 16'd0, 8'hFF);
        issue_command(taq_pkg::OP_TICK, 16'd0, 8'h00);
        issue_command(taq_pkg::OP_TICK, 16'd0, 8'h00);
        issue_command(taq_pkg::OP_SET, 16'hFFFF, 8'hFF);
        issue_command(taq_pkg::OP_SET, 16'd101, 8'h00);
    endtask

    // Random alarms and ticks, then a few more ticks to fire what has come due.
    task automatic test_random_traffic(int pct, int count);
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 40)
                issue_command(taq_pkg::OP_TICK, taq_pkg::DELAY_W'($urandom),
                              taq_pkg::TAG_W'($urandom));
            else
                issue_command(taq_pkg::OP_SET, pick_delay(), taq_pkg::TAG_W'($urandom));
        end
        for (int i = 0; i < DRAIN_TICKS && model_alarms.size() > 0; i++)
            issue_command(taq_pkg::OP_TICK, '0, '0);
    endtask

    always @(posedge i_clk) begin : check_results
        t_report exp_r;
        if (i_rst_n && o_strobe) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result: status %0d tag %0h", o_status, o_fired_tag);
                fail_count++;
            end else begin
                exp_r = expected_reports.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                    fail_count++;
                end
                if (o_fired_tag !== exp_r.tag) begin
                    $error("fired_tag: expected %0h, actual %0h", exp_r.tag, o_fired_tag);
                    fail_count++;
                end
                if (o_now_ticks !== exp_r.now) begin
                    $error("now_ticks: expected %0d, actual %0d", exp_r.now, o_now_ticks);
                    fail_count++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0b, actual %0b", exp_r.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tick_alarm_queue test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 22;
        test_zero_and_short_delays();
        test_full_queue_and_max_burst();
        test_random_traffic(22, 135);
        test_random_traffic(74, 135);
        test_random_traffic(0, 135);
        start <= 1'b0;
        while (expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("tick_alarm_queue test passed");
        else
            $display("tick_alarm_queue test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/taq_pkg.sv
sv/taq_ram.sv
sv/taq_dp.sv
sv/taq_ctrl.sv
sv/tick_alarm_queue.sv
tb/sv/tb_top.sv
